// ----- rtl/sha512_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 stream hasher package
// Shared types, round constants and a rotate helper function.
// ---------------------------------------------------------------------------
package sha512_pkg;

   typedef struct packed {
      logic [63:0] message_bytes;
      logic [3:0]  byte_count;
      logic        end_of_message;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_item;   // merge accepted item into block words
      logic       start_block; // load working vars from hash words
      logic       do_round;
      logic       do_update;   // add working vars into hash words
      logic       build_pad;   // write padding into buffer
      logic       pad_second;  // second pad block (zeros + length only)
      logic       restart;
      logic       shift_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       block_full;  // this load fills the buffer
      logic       round_last;
      logic       pad_two;     // padding needs two blocks
      logic       out_last;
   } sts_type;

   localparam logic [63:0] INIT_WORDS [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

   localparam logic [63:0] ROUND_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam int         LEN_START  = 112;
   localparam int         BLOCK_SIZE = 128;
   localparam int         ROUNDS     = 80;

   function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
      ror64 = (x >> n) | (x << (64 - n));
   endfunction

endpackage

// ----- rtl/sha512_stream_hasher.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 stream hasher
// Byte-stream SHA-512 with controller/datapath split and registered output.
// ---------------------------------------------------------------------------
// Usage: send 0..8 bytes per req_ transfer, earliest byte in bits 63..56;
// byte_count gives the valid leading bytes (above 8 counts as 8). Set
// end_of_message on the last transfer; it may carry zero bytes.
// A transfer that does not fill the 128-byte block is taken at once. A
// transfer that fills it starts a compression of 80 rounds, one per cycle
// on the single shared round unit, then the hash update; req_stall holds
// off further transfers until the update is done.
// End of message: one or two padded blocks are compressed, then eight
// rsp_ transfers carry digest words 0..7 with last_word on word 7.
// req_stall stays high until the last word has been loaded into the
// output register. The hasher then restarts with the initial hash.
// A stalled rsp_ transfer holds its payload; the next word waits.
// Reset loads the initial hash, clears the fill and length counters and the output valid.
// ---------------------------------------------------------------------------
module sha512_stream_hasher
   import sha512_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type     cmd;
   sts_type     sts;
   logic        rsp_load;
   logic [63:0] out_word;
   logic [2:0]  out_index;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        out_busy;

   assign out_busy = rsp_valid_ff && rsp_stall;

   sha512_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_eom   (req_data.end_of_message),
      .out_busy  (out_busy),
      .sts       (sts),
      .req_stall (req_stall),
      .rsp_load  (rsp_load),
      .cmd       (cmd)
   );

   sha512_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .out_word  (out_word),
      .out_index (out_index)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.digest_word = out_word;
         rsp_data_in.word_index  = out_index;
         rsp_data_in.last_word   = (out_index == 3'd7);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no new output word over a stalled one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output overwritten while stalled");

   // input is held off while a block is being compressed
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.do_round |-> req_stall)
      else $error("input accepted during compression");

   // digest words leave in order
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_word) ##1 (rsp_valid && !rsp_stall)
      |-> rsp_data.word_index == $past(rsp_data.word_index) + 3'd1)
      else $error("digest word out of order");

endmodule

// ----- rtl/sha512_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 controller
// Sequences item loading, block compression, padding and digest output.
// ---------------------------------------------------------------------------
module sha512_ctrl
   import sha512_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_eom,
   input  logic    out_busy,
   input  sts_type sts,
   output logic    req_stall,
   output logic    rsp_load,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      eom_ff, eom_in;
   logic      second_ff, second_in; // pad block two still to do
   logic      fin_ff, fin_in;       // padding under way, digest follows

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         eom_ff    <= 1'b0;
         second_ff <= 1'b0;
         fin_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         eom_ff    <= eom_in;
         second_ff <= second_in;
         fin_ff    <= fin_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      eom_in    = eom_ff;
      second_in = second_ff;
      fin_in    = fin_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               eom_in        = req_eom;
               if (sts.block_full) begin
                  cmd.start_block = 1'b1;
                  state_in        = ST_ROUND;
               end else if (req_eom) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            if (sts.round_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.do_update = 1'b1;
            if (second_ff || eom_ff || fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (eom_ff) begin
               cmd.build_pad   = 1'b1;
               cmd.start_block = 1'b1;
               second_in       = sts.pad_two;
               eom_in          = 1'b0;
               fin_in          = 1'b1;
               state_in        = ST_ROUND;
            end else if (second_ff) begin
               cmd.build_pad   = 1'b1;
               cmd.pad_second  = 1'b1;
               cmd.start_block = 1'b1;
               second_in       = 1'b0;
               state_in        = ST_ROUND;
            end else begin
               // hash words are final once the last pad block is in
               fin_in   = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_busy) begin
               rsp_load      = 1'b1;
               cmd.shift_out = 1'b1;
               if (sts.out_last) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/sha512_dpath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 datapath
// Block buffer as 16 word registers, message schedule, round unit, hash words.
// ---------------------------------------------------------------------------
module sha512_dpath
   import sha512_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [63:0] out_word,
   output logic [2:0]  out_index
);

   logic [63:0] w_ff [16];
   logic [63:0] w_in [16];
   logic [63:0] v_ff [8];
   logic [63:0] v_in [8];
   logic [63:0] h_ff [8];
   logic [63:0] h_in [8];
   logic [6:0]  fill_ff, fill_in;
   logic [63:0] total_ff, total_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic [63:0] carry_ff, carry_in; // bytes past the block end, wait for word 0

   logic [3:0]   cnt;
   logic [7:0]   fill_sum;
   logic [127:0] blk;
   logic [127:0] newblk;
   logic [63:0]  s0, s1, wnext, big0, big1, ch, maj, t1, t2, lenbits;
   logic [6:0]   pos;

   // saturate oversize counts
   assign cnt      = (req.byte_count > 4'd8) ? 4'd8 : req.byte_count;
   assign fill_sum = {1'b0, fill_ff} + {4'd0, cnt};
   assign lenbits  = total_ff << 3;

   assign sts.block_full = fill_sum[7];
   assign sts.round_last = (round_ff == 7'(ROUNDS - 1));
   assign sts.pad_two    = (fill_ff >= 7'(LEN_START));
   assign sts.out_last   = (oidx_ff == 3'd7);
   assign out_word       = h_ff[oidx_ff];
   assign out_index      = oidx_ff;

   // schedule and round logic
   assign s0    = ror64(w_ff[1], 1) ^ ror64(w_ff[1], 8) ^ (w_ff[1] >> 7);
   assign s1    = ror64(w_ff[14], 19) ^ ror64(w_ff[14], 61) ^ (w_ff[14] >> 6);
   assign wnext = w_ff[0] + s0 + w_ff[9] + s1;
   assign big1  = ror64(v_ff[4], 14) ^ ror64(v_ff[4], 18) ^ ror64(v_ff[4], 41);
   assign ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign t1    = v_ff[7] + big1 + ch + ROUND_K[round_ff] + w_ff[0];
   assign big0  = ror64(v_ff[0], 28) ^ ror64(v_ff[0], 34) ^ ror64(v_ff[0], 39);
   assign maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t2    = big0 + maj;

   // item bytes land in at most two consecutive buffer words
   always_comb begin
      blk    = {w_ff[fill_ff[6:3]], w_ff[fill_ff[6:3] + 4'd1]};
      newblk = blk;
      for (int i = 0; i < 8; i++) begin
         pos = {4'd0, fill_ff[2:0]} + 7'(i);
         if (4'(i) < cnt) newblk[127 - 8 * pos -: 8] = req.message_bytes[63 - 8 * i -: 8];
      end
   end

   always_comb begin
      w_in     = w_ff;
      v_in     = v_ff;
      h_in     = h_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      round_in = round_ff;
      oidx_in  = oidx_ff;
      carry_in = carry_ff;
      if (cmd.load_item) begin
         w_in[fill_ff[6:3]] = newblk[127:64];
         // hold spill-over bytes until the full block is compressed
         if (fill_sum[7]) carry_in = newblk[63:0];
         else             w_in[fill_ff[6:3] + 4'd1] = newblk[63:0];
         fill_in  = fill_sum[6:0];
         total_in = total_ff + {60'd0, cnt};
      end
      if (cmd.build_pad) begin
         for (int k = 0; k < 16; k++) begin
            if (cmd.pad_second) begin
               w_in[k] = '0;
            end else if (k > int'(fill_ff[6:3])) begin
               w_in[k] = '0;
            end else if (k == int'(fill_ff[6:3])) begin
               w_in[k] = w_ff[k] & ~(64'hffffffffffffffff >> (8 * fill_ff[2:0]));
               w_in[k][63 - 8 * fill_ff[2:0] -: 8] = PAD_BYTE;
            end
         end
         if (cmd.pad_second || !sts.pad_two) begin
            w_in[14] = '0;
            w_in[15] = lenbits;
         end
      end
      if (cmd.start_block) begin
         v_in     = h_ff;
         round_in = '0;
      end
      if (cmd.do_round) begin
         for (int k = 0; k < 15; k++) w_in[k] = w_ff[k + 1];
         w_in[15] = wnext;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         round_in = round_ff + 7'd1;
      end
      if (cmd.do_update) begin
         for (int k = 0; k < 8; k++) h_in[k] = h_ff[k] + v_ff[k];
         w_in[0] = carry_ff;
      end
      if (cmd.shift_out) oidx_in = oidx_ff + 3'd1;
      if (cmd.restart) begin
         for (int k = 0; k < 8; k++) h_in[k] = INIT_WORDS[k];
         fill_in  = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 8; k++) h_ff[k] <= INIT_WORDS[k];
         fill_ff  <= '0;
         total_ff <= '0;
         round_ff <= '0;
         oidx_ff  <= '0;
      end else begin
         h_ff     <= h_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         round_ff <= round_in;
         oidx_ff  <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      v_ff     <= v_in;
      carry_ff <= carry_in;
   end

endmodule

// ----- tb/sha512_stream_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 stream checker
// Watches the req_ and rsp_ channels, hashes accepted bytes on its own and
// compares every digest word transfer with the predicted word.
// ---------------------------------------------------------------------------
module sha512_stream_checker
   import sha512_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_words,
   output int      digest_count
);

   localparam logic [63:0] K_TAB [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   localparam logic [63:0] IV_TAB [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

   logic [63:0] chain [8];
   logic [7:0]  blk [128];
   int          fill;
   logic [63:0] msg_len;
   rsp_type     digest_queue [$];

   function automatic logic [63:0] rotr(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   task automatic compress_block();
      logic [63:0] w [80];
      logic [63:0] v [8];
      logic [63:0] t1, t2, x, y;
      for (int i = 0; i < 16; i++) begin
         w[i] = '0;
         for (int j = 0; j < 8; j++) w[i] = {w[i][55:0], blk[i*8+j]};
      end
      for (int i = 16; i < 80; i++) begin
         x = w[i-15];
         y = w[i-2];
         w[i] = w[i-16] + (rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7)) + w[i-7]
              + (rotr(y, 19) ^ rotr(y, 61) ^ (y >> 6));
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 80; i++) begin
         t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
         t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int k = 7; k > 0; k--) v[k] = v[k-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endtask

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) chain[i] = IV_TAB[i];
      fill = 0;
      msg_len = '0;
   endtask

   task automatic absorb_item(req_type it);
      int          n;
      int          p;
      logic [63:0] bits;
      rsp_type     r;
      n = (it.byte_count > 8) ? 8 : it.byte_count;
      for (int i = 0; i < n; i++) begin
         blk[fill] = it.message_bytes[63-8*i -: 8];
         fill = (fill + 1) % 128;
         if (fill == 0) compress_block();
      end
      msg_len = msg_len + n;
      if (!it.end_of_message) return;
      bits = msg_len << 3;
      p = fill;
      blk[p++] = 8'h80;
      if (p > 112) begin
         while (p < 128) blk[p++] = 8'h00;
         compress_block();
         p = 0;
      end
      while (p < 120) blk[p++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[120+i] = bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         r.digest_word = chain[i];
         r.word_index = 3'(i);
         r.last_word = (i == 7);
         digest_queue.push_back(r);
      end
      restart_hash();
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      digest_count = 0;
      pending_words = 0;
      restart_hash();
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) absorb_item(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               report_mismatch("unexpected word", rsp_data.digest_word, '0);
            end else begin
               want = digest_queue.pop_front();
               if (rsp_data.digest_word != want.digest_word)
                  report_mismatch("digest_word", rsp_data.digest_word, want.digest_word);
               if (rsp_data.word_index != want.word_index)
                  report_mismatch("word_index", rsp_data.word_index, want.word_index);
               if (rsp_data.last_word != want.last_word)
                  report_mismatch("last_word", rsp_data.last_word, want.last_word);
               if (want.last_word) digest_count++;
            end
         end
      end
      pending_words = digest_queue.size();
   end

endmodule

// ----- tb/sha512_stream_hasher_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 stream hasher testbench
// Sends directed and random byte streams, some with random gaps, under output stalls;
// the checker predicts each digest and compares every word.
// ---------------------------------------------------------------------------
module sha512_stream_hasher_tb;
   import sha512_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      pending_words;
   int      digest_count;
   int      cycle_count = 0;
   int      item_count = 0;
   bit      stim_done = 1'b0;

   sha512_stream_hasher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   sha512_stream_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .error_count(error_count), .pending_words(pending_words),
      .digest_count(digest_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // draw a fresh stall pattern per word: a random stall hold before each word
   initial begin
      int hold;
      @(negedge clock);
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_item(logic [63:0] bytes, logic [3:0] cnt, logic eom, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= '{message_bytes: bytes, byte_count: cnt, end_of_message: eom};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      item_count++;
   endtask

   task automatic random_message(bit gaps);
      int len;
      logic [3:0] cnt;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
         cnt = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
         send_item({$urandom, $urandom}, cnt, 1'b0, gaps);
      end
      send_item({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1, gaps);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      // empty message, then extremes of data and count
      send_item('0, 4'd0, 1'b1, 1'b0);
      send_item(64'h6162630000000000, 4'd3, 1'b1, 1'b0);
      send_item('1, 4'd8, 1'b1, 1'b0);
      send_item('1, 4'd15, 1'b0, 1'b0);
      send_item('0, 4'd9, 1'b1, 1'b0);
      send_item(64'hA5A5_5A5A_FFFF_0000, 4'd1, 1'b1, 1'b0);
      // 111 and 112 bytes straddle the one/two block padding boundary
      for (int i = 0; i < 13; i++) send_item({$urandom, $urandom}, 4'd8, 1'b0, 1'b0);
      send_item({$urandom, $urandom}, 4'd7, 1'b1, 1'b0);
      for (int i = 0; i < 14; i++) send_item({$urandom, $urandom}, 4'd8, 1'b0, 1'b0);
      send_item('0, 4'd0, 1'b1, 1'b0);
      // exactly one full block, then finish with no bytes
      for (int i = 0; i < 16; i++) send_item({$urandom, $urandom}, 4'd8, 1'b0, 1'b0);
      send_item('0, 4'd0, 1'b1, 1'b0);
      while (item_count < 150) random_message(1'b1);
      // let the pipeline drain completely before resuming
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      while (item_count < 230) random_message(1'b0);
      while (item_count < 310) random_message(1'b1);
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d items over %0d messages with random gaps and stalls.",
               item_count, digest_count);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/sha512_pkg.sv
rtl/sha512_ctrl.sv
rtl/sha512_dpath.sv
rtl/sha512_stream_hasher.sv
tb/sha512_stream_checker.sv
tb/sha512_stream_hasher_tb.sv
